>>> design/tnrn_pkg.sv
// Shared codes, types and reply tables of the telnet receive negotiator.
package tnrn_pkg;

   localparam int SUB_MAX_LEN_DEFAULT = 64;
   localparam int HEAD_LEN = 5;

   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_AYT  = 8'd246;
   localparam logic [7:0] B_IP   = 8'd244;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_SUSP = 8'd237;

   localparam logic [7:0] OPT_TTYPE = 8'd24;
   localparam logic [7:0] OPT_NAWS  = 8'd31;
   localparam logic [7:0] OPT_LFLOW = 8'd33;
   localparam logic [7:0] OPT_COMP2 = 8'd86;
   localparam logic [7:0] TTYPE_IS   = 8'd0;
   localparam logic [7:0] TTYPE_SEND = 8'd1;

   localparam logic [3:0] F_WILL = 4'b0001;
   localparam logic [3:0] F_WONT = 4'b0010;
   localparam logic [3:0] F_DO   = 4'b0100;
   localparam logic [3:0] F_DONT = 4'b1000;

   localparam logic [2:0] KIND_DATA       = 3'd0;
   localparam logic [2:0] KIND_REPLY      = 3'd1;
   localparam logic [2:0] KIND_DISCONNECT = 3'd2;
   localparam logic [2:0] KIND_WINDOW     = 3'd3;
   localparam logic [2:0] KIND_COMPRESS   = 3'd4;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_OPTION = 2'd1;
   localparam logic [1:0] MODE_TTYPE  = 2'd2;
   localparam logic [1:0] MODE_AYT    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [7:0]  cmd;
      logic [15:0] cols;
      logic [15:0] rows;
   } burst_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [3:0] data;
   } flag_wr_type;

   function automatic logic [3:0] burst_len(input logic [1:0] mode);
      logic [3:0] len;
      unique case (mode)
         MODE_SINGLE: len = 4'd1;
         MODE_OPTION: len = 4'd3;
         MODE_TTYPE:  len = 4'd6;
         MODE_AYT:    len = 4'd10;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] flag_of(input logic [7:0] cmd);
      logic [3:0] f;
      priority case (cmd)
         B_WILL:  f = F_WILL;
         B_WONT:  f = F_WONT;
         B_DO:    f = F_DO;
         default: f = F_DONT;
      endcase
      return f;
   endfunction

   function automatic logic [7:0] ttype_byte(input logic [3:0] idx);
      logic [7:0] v;
      priority case (idx)
         4'd0:    v = B_IAC;
         4'd1:    v = B_SB;
         4'd2:    v = OPT_TTYPE;
         4'd3:    v = TTYPE_SEND;
         4'd4:    v = B_IAC;
         default: v = B_SE;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] ayt_byte(input logic [3:0] idx);
      logic [7:0] v;
      priority case (idx)
         4'd0:    v = 8'd7;
         4'd1:    v = 8'd40;
         4'd2:    v = 8'd40;
         4'd3:    v = 8'd65;
         4'd4:    v = 8'd121;
         4'd5:    v = 8'd101;
         4'd6:    v = 8'd41;
         4'd7:    v = 8'd41;
         4'd8:    v = 8'd13;
         default: v = 8'd10;
      endcase
      return v;
   endfunction

endpackage

>>> design/tnrn_flag_store.sv
// Per-option sent-flag memory with valid bits and write-to-read bypass.
module tnrn_flag_store
   import tnrn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [7:0]  rd_addr,
   input  flag_wr_type flag_wr,
   output logic [3:0]  rd_data
);

   logic [3:0]   flag_mem_ff [256];
   logic [255:0] valid_ff;
   logic [3:0]   mem_q_ff;
   logic         valid_q_ff;
   logic         byp_ff;
   logic [3:0]   byp_data_ff;

   always_ff @(posedge clock) begin
      if (flag_wr.en) begin
         flag_mem_ff[flag_wr.addr] <= flag_wr.data;
      end
      if (rd_en) begin
         mem_q_ff    <= flag_mem_ff[rd_addr];
         valid_q_ff  <= valid_ff[rd_addr];
         byp_ff      <= flag_wr.en && (flag_wr.addr == rd_addr);
         byp_data_ff <= flag_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (flag_wr.en) begin
         valid_ff[flag_wr.addr] <= 1'b1;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (valid_q_ff ? mem_q_ff : 4'd0);

endmodule

>>> design/tnrn_parser.sv
// Input register, IAC parse state, negotiation and subnegotiation evaluation.
module tnrn_parser
   import tnrn_pkg::*;
#(
   parameter int SUB_MAX_LEN = SUB_MAX_LEN_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [3:0]  flags_rd,
   input  logic        take,
   output logic        rd_en,
   output logic [7:0]  rd_addr,
   output flag_wr_type flag_wr,
   output logic        burst_load,
   output burst_type   burst
);

   localparam int CNT_W = $clog2(SUB_MAX_LEN + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(SUB_MAX_LEN);
   localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(HEAD_LEN);

   localparam logic [2:0] ST_DATA   = 3'd0;
   localparam logic [2:0] ST_IAC    = 3'd1;
   localparam logic [2:0] ST_WILL   = 3'd2;
   localparam logic [2:0] ST_WONT   = 3'd3;
   localparam logic [2:0] ST_DO     = 3'd4;
   localparam logic [2:0] ST_DONT   = 3'd5;
   localparam logic [2:0] ST_SB     = 3'd6;
   localparam logic [2:0] ST_SB_IAC = 3'd7;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       byte_ff;
   logic [2:0]       state_ff, state_in;
   logic             closed_ff, closed_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       head_ff [HEAD_LEN];
   logic [7:0]       head_in [HEAD_LEN];

   logic             accept, fire;
   logic [CNT_W-1:0] col_cnt;
   logic [7:0]       col_head [HEAD_LEN];
   logic             eval_load;
   burst_type        eval_burst;
   logic             neg_load;
   burst_type        neg_burst;
   flag_wr_type      neg_wr;

   assign fire      = in_valid_ff && take;
   assign req_ready = !in_valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign rd_en     = accept;
   assign rd_addr   = req_rx_byte;
   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_DATA;
         closed_ff   <= 1'b0;
         cnt_ff      <= '0;
         for (int i = 0; i < HEAD_LEN; i++) begin
            head_ff[i] <= 8'd0;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         closed_ff   <= closed_in;
         cnt_ff      <= cnt_in;
         head_ff     <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   // collect one byte, saturating at the length bound
   always_comb begin
      col_cnt  = cnt_ff;
      col_head = head_ff;
      if (cnt_ff < MAX_CNT) begin
         col_cnt = cnt_ff + 1'b1;
         for (int i = 0; i < HEAD_LEN; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               col_head[i] = byte_ff;
            end
         end
      end
   end

   always_comb begin
      eval_load  = 1'b0;
      eval_burst = '0;
      if (cnt_ff != '0) begin
         if (head_ff[0] == OPT_TTYPE) begin
            if (cnt_ff >= CNT_W'(2) && head_ff[1] == TTYPE_IS) begin
               eval_load       = 1'b1;
               eval_burst.mode = MODE_TTYPE;
               eval_burst.kind = KIND_REPLY;
            end
         end else if (head_ff[0] == OPT_NAWS) begin
            if (cnt_ff >= HEAD_CNT) begin
               eval_load       = 1'b1;
               eval_burst.mode = MODE_SINGLE;
               eval_burst.kind = KIND_WINDOW;
               eval_burst.cols = {head_ff[1], head_ff[2]};
               eval_burst.rows = {head_ff[3], head_ff[4]};
            end
         end
      end
   end

   always_comb begin
      logic       send, ttype, comp;
      logic [7:0] rc;
      logic [3:0] rf;
      send = 1'b0;
      ttype = 1'b0;
      comp = 1'b0;
      rc = B_DONT;
      if (state_ff == ST_WILL) begin
         if (!flags_rd[3] && !flags_rd[2]) begin
            send = 1'b1;
            rc = (byte_ff == OPT_TTYPE || byte_ff == OPT_NAWS || byte_ff == OPT_LFLOW)
                 ? B_DO : B_DONT;
         end else if (byte_ff == OPT_TTYPE) begin
            ttype = 1'b1;
         end
      end else if (state_ff == ST_WONT) begin
         send = !flags_rd[3];
         rc = B_DONT;
      end else if (state_ff == ST_DO) begin
         if (!flags_rd[0] && !flags_rd[1]) begin
            send = 1'b1;
            rc = (byte_ff == OPT_COMP2) ? B_WILL : B_WONT;
         end else if (byte_ff == OPT_COMP2) begin
            comp = 1'b1;
         end
      end else begin
         send = !flags_rd[0];
         rc = B_WONT;
      end
      rf = flag_of(rc);
      neg_load  = 1'b0;
      neg_burst = '0;
      neg_wr    = '0;
      if (send && (flags_rd & rf) == 4'd0) begin
         neg_load        = 1'b1;
         neg_burst.mode  = MODE_OPTION;
         neg_burst.kind  = KIND_REPLY;
         neg_burst.cmd   = rc;
         neg_burst.value = byte_ff;
         neg_wr.en       = 1'b1;
         neg_wr.addr     = byte_ff;
         neg_wr.data     = rf;
      end else if (ttype) begin
         neg_load       = 1'b1;
         neg_burst.mode = MODE_TTYPE;
         neg_burst.kind = KIND_REPLY;
      end else if (comp) begin
         neg_load       = 1'b1;
         neg_burst.mode = MODE_SINGLE;
         neg_burst.kind = KIND_COMPRESS;
      end
   end

   always_comb begin
      state_in   = state_ff;
      closed_in  = closed_ff;
      cnt_in     = cnt_ff;
      head_in    = head_ff;
      burst_load = 1'b0;
      burst      = '0;
      flag_wr    = '0;
      if (fire && !closed_ff) begin
         unique case (state_ff)
            ST_DATA: begin
               if (byte_ff == B_IAC) begin
                  state_in = ST_IAC;
               end else begin
                  burst_load  = 1'b1;
                  burst.mode  = MODE_SINGLE;
                  burst.kind  = KIND_DATA;
                  burst.value = byte_ff;
               end
            end
            ST_IAC: begin
               state_in = ST_DATA;
               priority if (byte_ff == B_IAC) begin
                  burst_load  = 1'b1;
                  burst.mode  = MODE_SINGLE;
                  burst.kind  = KIND_DATA;
                  burst.value = byte_ff;
               end else if (byte_ff == B_IP || byte_ff == B_SUSP) begin
                  burst_load = 1'b1;
                  burst.mode = MODE_SINGLE;
                  burst.kind = KIND_DISCONNECT;
                  closed_in  = 1'b1;
               end else if (byte_ff == B_AYT) begin
                  burst_load = 1'b1;
                  burst.mode = MODE_AYT;
                  burst.kind = KIND_REPLY;
               end else if (byte_ff == B_WILL) begin
                  state_in = ST_WILL;
               end else if (byte_ff == B_WONT) begin
                  state_in = ST_WONT;
               end else if (byte_ff == B_DO) begin
                  state_in = ST_DO;
               end else if (byte_ff == B_DONT) begin
                  state_in = ST_DONT;
               end else if (byte_ff == B_SB) begin
                  state_in = ST_SB;
                  cnt_in   = '0;
               end else if (byte_ff == B_SE) begin
                  burst_load = eval_load;
                  burst      = eval_burst;
                  cnt_in     = '0;
               end else begin
                  state_in = ST_DATA;
               end
            end
            ST_WILL, ST_WONT, ST_DO, ST_DONT: begin
               state_in   = ST_DATA;
               burst_load = neg_load;
               burst      = neg_burst;
               flag_wr    = neg_wr;
            end
            ST_SB: begin
               if (byte_ff == B_IAC) begin
                  state_in = ST_SB_IAC;
               end else begin
                  cnt_in  = col_cnt;
                  head_in = col_head;
               end
            end
            ST_SB_IAC: begin
               if (byte_ff == B_IAC) begin
                  state_in = ST_SB;
                  cnt_in   = col_cnt;
                  head_in  = col_head;
               end else begin
                  state_in = ST_DATA;
                  if (byte_ff == B_SE) begin
                     burst_load = eval_load;
                     burst      = eval_burst;
                     cnt_in     = '0;
                  end
               end
            end
         endcase
      end
   end

   a_closed_holds: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed flag dropped");

   a_write_has_reply: assert property (@(posedge clock) disable iff (reset)
      flag_wr.en |-> burst_load && burst.mode == MODE_OPTION)
      else $error("flag write without option reply");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("subnegotiation count beyond bound");

endmodule

>>> design/tnrn_serializer.sv
// Result register that plays out one burst of results, one item per cycle while rsp_ready is high.
module tnrn_serializer
   import tnrn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        burst_load,
   input  burst_type   burst,
   output logic        take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_columns,
   output logic [15:0] rsp_rows,
   output logic        rsp_last
);

   logic      valid_ff, valid_in;
   logic [3:0] idx_ff, idx_in;
   burst_type burst_ff;
   logic      at_last, sent;

   assign at_last = (idx_ff == burst_len(burst_ff.mode) - 4'd1);
   assign sent    = valid_ff && rsp_ready;
   assign take    = !valid_ff || (rsp_ready && at_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (burst_load) begin
         valid_in = 1'b1;
         idx_in   = 4'd0;
      end else if (sent) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (burst_load) begin
         burst_ff <= burst;
      end
   end

   always_comb begin
      unique case (burst_ff.mode)
         MODE_SINGLE: rsp_byte_value = burst_ff.value;
         MODE_OPTION: begin
            priority case (idx_ff)
               4'd0:    rsp_byte_value = B_IAC;
               4'd1:    rsp_byte_value = burst_ff.cmd;
               default: rsp_byte_value = burst_ff.value;
            endcase
         end
         MODE_TTYPE:  rsp_byte_value = ttype_byte(idx_ff);
         MODE_AYT:    rsp_byte_value = ayt_byte(idx_ff);
      endcase
   end

   assign rsp_valid   = valid_ff;
   assign rsp_kind    = burst_ff.kind;
   assign rsp_columns = burst_ff.cols;
   assign rsp_rows    = burst_ff.rows;
   assign rsp_last    = at_last;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < burst_len(burst_ff.mode))
      else $error("burst index past burst length");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> take)
      else $error("burst loaded while busy");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      sent && at_last && !burst_load |=> !valid_ff)
      else $error("result register still full after final item");

endmodule

>>> design/telnet_receive_negotiator_core.sv
// Telnet receive negotiator: IAC parser with option replies and result serializer.
// A result passes through the parser input register and then the serializer result register.
// Throughput: one input item per cycle while each item yields at most one result and rsp_ready is high;
// an item with n results (up to ten) holds the result register until its last result is taken.
// The option flag memory is read when an item is accepted, with bypass of the write in flight.
// Reset is synchronous: parse state, counts and all 256 flag valid bits clear at once.
module telnet_receive_negotiator_core
   import tnrn_pkg::*;
#(
   parameter int SUB_MAX_LEN = SUB_MAX_LEN_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_columns,
   output logic [15:0] rsp_rows,
   output logic        rsp_last
);

   logic        rd_en;
   logic [7:0]  rd_addr;
   logic [3:0]  flags_rd;
   flag_wr_type flag_wr;
   logic        take;
   logic        burst_load;
   burst_type   burst;

   tnrn_flag_store u_flag_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .flag_wr (flag_wr),
      .rd_data (flags_rd)
   );

   tnrn_parser #(
      .SUB_MAX_LEN (SUB_MAX_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .flags_rd    (flags_rd),
      .take        (take),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .flag_wr     (flag_wr),
      .burst_load  (burst_load),
      .burst       (burst)
   );

   tnrn_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .burst_load     (burst_load),
      .burst          (burst),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_columns    (rsp_columns),
      .rsp_rows       (rsp_rows),
      .rsp_last       (rsp_last)
   );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the telnet receive negotiator: directed and random byte streams.
module testbench;
   import tnrn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUB_MAX_LEN  = SUB_MAX_LEN_DEFAULT;
   localparam int RANDOM_ITEMS = 85;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [7:0] B_NOP = 8'd241;

   typedef enum logic [2:0] {
      PS_DATA, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT, PS_SB, PS_SB_IAC
   } parse_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [15:0] columns;
      logic [15:0] rows;
      logic        last;
   } rx_result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      logic [2:0] kind;
      logic [7:0] value;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [15:0] rsp_columns;
   logic [15:0] rsp_rows;
   logic        rsp_last;

   parse_type   parse;
   logic [3:0]  option_flags [256];
   int          sub_len;
   logic [7:0]  sub_head [HEAD_LEN];
   bit          link_closed;

   rx_result_type byte_results [$];
   rx_result_type pending_results [$];
   int          errors;
   int          accepted_bytes;
   bit          close_ok;
   bit          req_quiet;
   bit          rsp_quiet;

   logic [7:0]  ayt_text [10] = '{8'd7, 8'd40, 8'd40, 8'd65, 8'd121, 8'd101, 8'd41, 8'd41,
                                   8'd13, 8'd10};

   stim_row_type directed_rows [29] = '{
      '{8'd0,      1'b1, KIND_DATA, 8'd0},
      '{8'd254,    1'b1, KIND_DATA, 8'd254},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b1, KIND_DATA, 8'd255},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_WILL,    1'b0, KIND_DATA, 8'd0},
      '{OPT_TTYPE, 1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_WILL,    1'b0, KIND_DATA, 8'd0},
      '{OPT_TTYPE, 1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_DO,      1'b0, KIND_DATA, 8'd0},
      '{OPT_COMP2, 1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_DO,      1'b0, KIND_DATA, 8'd0},
      '{OPT_COMP2, 1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_AYT,     1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_SB,      1'b0, KIND_DATA, 8'd0},
      '{OPT_NAWS,  1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{8'd0,      1'b0, KIND_DATA, 8'd0},
      '{8'd0,      1'b0, KIND_DATA, 8'd0},
      '{B_IAC,     1'b0, KIND_DATA, 8'd0},
      '{B_SE,      1'b0, KIND_DATA, 8'd0}
   };

   telnet_receive_negotiator_core #(.SUB_MAX_LEN(SUB_MAX_LEN)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_columns    (rsp_columns),
      .rsp_rows       (rsp_rows),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_result(logic [2:0] kind, logic [7:0] value,
                                      logic [15:0] cols, logic [15:0] rows);
      rx_result_type r;
      r = '{kind, value, cols, rows, 1'b0};
      byte_results.push_back(r);
   endfunction

   function automatic void add_reply(logic [7:0] value);
      add_result(KIND_REPLY, value, 16'd0, 16'd0);
   endfunction

   function automatic void offer_option(logic [7:0] cmd, logic [7:0] opt);
      logic [3:0] f;
      case (cmd)
         B_WILL:  f = F_WILL;
         B_WONT:  f = F_WONT;
         B_DO:    f = F_DO;
         default: f = F_DONT;
      endcase
      if ((option_flags[opt] & f) == 4'b0) begin
         option_flags[opt] = f;
         add_reply(B_IAC);
         add_reply(cmd);
         add_reply(opt);
      end
   endfunction

   function automatic void request_ttype();
      add_reply(B_IAC);
      add_reply(B_SB);
      add_reply(OPT_TTYPE);
      add_reply(TTYPE_SEND);
      add_reply(B_IAC);
      add_reply(B_SE);
   endfunction

   function automatic void finish_subneg();
      if (sub_len != 0) begin
         if (sub_head[0] == OPT_TTYPE) begin
            if (sub_len >= 2 && sub_head[1] == TTYPE_IS) request_ttype();
         end else if (sub_head[0] == OPT_NAWS) begin
            if (sub_len >= 5)
               add_result(KIND_WINDOW, 8'd0, {sub_head[1], sub_head[2]},
                          {sub_head[3], sub_head[4]});
         end
         sub_len = 0;
      end
   endfunction

   function automatic void collect(logic [7:0] b);
      if (sub_len < SUB_MAX_LEN) begin
         if (sub_len < HEAD_LEN) sub_head[sub_len] = b;
         sub_len++;
      end
   endfunction

   function automatic void negotiate_byte(logic [7:0] b);
      logic [3:0] f;
      byte_results.delete();
      if (!link_closed) begin
         case (parse)
            PS_DATA: begin
               if (b == B_IAC) parse = PS_IAC;
               else add_result(KIND_DATA, b, 16'd0, 16'd0);
            end
            PS_IAC: begin
               parse = PS_DATA;
               if (b == B_IAC) begin
                  add_result(KIND_DATA, b, 16'd0, 16'd0);
               end else if (b == B_IP || b == B_SUSP) begin
                  add_result(KIND_DISCONNECT, 8'd0, 16'd0, 16'd0);
                  link_closed = 1'b1;
               end else if (b == B_AYT) begin
                  foreach (ayt_text[i]) add_reply(ayt_text[i]);
               end else if (b == B_WILL) begin
                  parse = PS_WILL;
               end else if (b == B_WONT) begin
                  parse = PS_WONT;
               end else if (b == B_DO) begin
                  parse = PS_DO;
               end else if (b == B_DONT) begin
                  parse = PS_DONT;
               end else if (b == B_SB) begin
                  parse = PS_SB;
                  sub_len = 0;
               end else if (b == B_SE) begin
                  finish_subneg();
               end
            end
            PS_WILL, PS_WONT, PS_DO, PS_DONT: begin
               f = option_flags[b];
               case (parse)
                  PS_WILL: begin
                     if ((f & (F_DONT | F_DO)) == 4'b0) begin
                        if (b == OPT_TTYPE || b == OPT_NAWS || b == OPT_LFLOW)
                           offer_option(B_DO, b);
                        else
                           offer_option(B_DONT, b);
                     end else if (b == OPT_TTYPE) begin
                        request_ttype();
                     end
                  end
                  PS_WONT: begin
                     if ((f & F_DONT) == 4'b0) offer_option(B_DONT, b);
                  end
                  PS_DO: begin
                     if ((f & (F_WILL | F_WONT)) == 4'b0) begin
                        offer_option((b == OPT_COMP2) ? B_WILL : B_WONT, b);
                     end else if (b == OPT_COMP2) begin
                        add_result(KIND_COMPRESS, 8'd0, 16'd0, 16'd0);
                     end
                  end
                  default: begin
                     if ((f & F_WILL) == 4'b0) offer_option(B_WONT, b);
                  end
               endcase
               parse = PS_DATA;
            end
            PS_SB: begin
               if (b == B_IAC) parse = PS_SB_IAC;
               else collect(b);
            end
            default: begin
               if (b == B_IAC) begin
                  collect(b);
                  parse = PS_SB;
               end else begin
                  parse = PS_DATA;
                  if (b == B_SE) finish_subneg();
               end
            end
         endcase
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
   endfunction

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic send_byte(input logic [7:0] rx, input bit typed,
                            input logic [2:0] kind, input logic [7:0] value);
      int gap;
      rx_result_type r;
      if (parse == PS_IAC && (rx == B_IP || rx == B_SUSP) && !close_ok) rx = B_NOP;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      negotiate_byte(rx);
      if (typed) begin
         r = '{kind, value, 16'd0, 16'd0, 1'b1};
         pending_results.push_back(r);
      end else begin
         foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
      end
      accepted_bytes++;
   endtask

   task automatic send_plain(input logic [7:0] rx);
      send_byte(rx, 1'b0, KIND_DATA, 8'd0);
   endtask

   task automatic send_sub(input logic [7:0] rx);
      send_plain(rx);
      if (rx == B_IAC) send_plain(rx);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(0, 7))
         0:       return OPT_TTYPE;
         1:       return OPT_NAWS;
         2:       return OPT_LFLOW;
         3:       return OPT_COMP2;
         4:       return 8'd0;
         5:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_sequence();
      int pick;
      int len;
      int ending;
      logic [7:0] opt;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         repeat ($urandom_range(1, 4)) send_plain(8'($urandom_range(0, 254)));
      end else if (pick < 25) begin
         send_plain(B_IAC);
         send_plain(B_IAC);
      end else if (pick < 50) begin
         send_plain(B_IAC);
         send_plain(8'($urandom_range(B_WILL, B_DONT)));
         send_plain(pick_option());
      end else if (pick < 55) begin
         send_plain(B_IAC);
         send_plain(B_AYT);
      end else if (pick < 62) begin
         send_plain(B_IAC);
         send_plain(($urandom_range(0, 2) == 0) ? B_SE : 8'($urandom_range(0, 249)));
      end else if (pick < 87) begin
         send_plain(B_IAC);
         send_plain(B_SB);
         if ($urandom_range(0, 9) != 0) begin
            opt = pick_option();
            send_sub(opt);
            if ($urandom_range(0, 12) == 0) len = $urandom_range(60, 70);
            else if (opt == OPT_NAWS) len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
            else len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               if (i == 0 && opt == OPT_TTYPE && $urandom_range(0, 3) != 0) send_sub(TTYPE_IS);
               else send_sub(8'($urandom_range(0, 255)));
            end
         end
         ending = $urandom_range(0, 9);
         if (ending < 8) begin
            send_plain(B_IAC);
            send_plain(B_SE);
         end else if (ending == 8) begin
            send_plain(B_IAC);
            send_plain(8'($urandom_range(0, 239)));
         end
      end else begin
         repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   initial begin
      rx_result_type want;
      int stall;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                     $time, rsp_kind, rsp_byte_value);
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("byte_value", 16'(want.value), 16'(rsp_byte_value));
            check_field("columns", want.columns, rsp_columns);
            check_field("rows", want.rows, rsp_rows);
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'd0;
      parse = PS_DATA;
      foreach (option_flags[i]) option_flags[i] = 4'b0;
      foreach (sub_head[i]) sub_head[i] = 8'd0;
      sub_len = 0;
      link_closed = 1'b0;
      close_ok = 1'b0;
      errors = 0;
      accepted_bytes = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].kind,
                   directed_rows[i].value);

      while (accepted_bytes < $size(directed_rows) + RANDOM_ITEMS) send_random_sequence();

      while (parse != PS_DATA) begin
         case (parse)
            PS_SB:    send_plain(B_IAC);
            PS_SB_IAC: send_plain(B_SE);
            PS_IAC:   send_plain(B_NOP);
            default:  send_plain(8'd0);
         endcase
      end
      close_ok = 1'b1;
      send_plain(B_IAC);
      send_plain(($urandom_range(0, 1) == 0) ? B_IP : B_SUSP);
      send_plain(B_IAC);
      send_plain(B_AYT);
      send_plain(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
